// ===== hw/rtl/pts_pkg.sv =====
// Shared types and constants for the point table nearest search block.
`default_nettype none

package pts_pkg;

    localparam int CMD_W     = 3;
    localparam int ST_W      = 3;
    localparam int IDXIN_W   = 6;
    localparam int RIDX_W    = 6;
    localparam int CNTOUT_W  = 7;
    localparam int RADIUS_W  = 12;
    localparam int R2_W      = 2 * RADIUS_W;
    localparam logic [RADIUS_W-1:0] RADIUS_RST = 12'd16;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND         = 3'd0,
        CMD_REMOVE_AT      = 3'd1,
        CMD_NEXT           = 3'd2,
        CMD_RESET_ITER     = 3'd3,
        CMD_SET_ITER       = 3'd4,
        CMD_CLOSEST        = 3'd5,
        CMD_GET_NTH        = 3'd6,
        CMD_REMOVE_CLOSEST = 3'd7
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 3'd0,
        ST_EMPTY  = 3'd1,
        ST_RANGE  = 3'd2,
        ST_FULL   = 3'd3,
        ST_RADIUS = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FETCH,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_SHINIT,
        S_SHIFT,
        S_EMIT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_APPEND,
        OP_RD_IDX,
        OP_RD_ITER,
        OP_FETCH,
        OP_FETCH_NEXT,
        OP_FETCH_SET,
        OP_RST_ITER,
        OP_SCAN_INIT,
        OP_SCAN,
        OP_SHIFT_INIT,
        OP_SHIFT,
        OP_REMOVE,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op     op;
        logic    set_res;
        t_status st;
        logic    show;
    } t_dp_ctl;

    typedef struct packed {
        t_cmd cmd;
        logic full;
        logic empty;
        logic idx_ok;
        logic iter_end;
        logic scan_last;
        logic pipe_busy;
        logic shift_done;
        logic in_radius;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== hw/rtl/pts_ctrl.sv =====
// Command sequencer for the point table: walks each item through its steps.
`default_nettype none

module pts_ctrl
    import pts_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    output logic         o_busy,
    input  wire t_dp_sts i_sts,
    output t_dp_ctl      o_ctl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.cmd) inside
                    CMD_APPEND, CMD_RESET_ITER: n_state = S_EMIT;
                    CMD_REMOVE_AT, CMD_SET_ITER, CMD_GET_NTH:
                        n_state = i_sts.idx_ok ? S_FETCH : S_EMIT;
                    CMD_NEXT: n_state = i_sts.iter_end ? S_EMIT : S_FETCH;
                    CMD_CLOSEST, CMD_REMOVE_CLOSEST:
                        n_state = i_sts.empty ? S_EMIT : S_SCAN;
                    default: n_state = S_EMIT;
                endcase
            end
            S_FETCH: n_state = (i_sts.cmd == CMD_REMOVE_AT) ? S_SHINIT : S_EMIT;
            S_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.cmd == CMD_REMOVE_CLOSEST && i_sts.in_radius) begin
                    n_state = S_SHINIT;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_SHINIT: n_state = S_SHIFT;
            S_SHIFT: begin
                if (i_sts.shift_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl         = '0;
        o_ctl.op      = OP_NONE;
        o_ctl.st      = ST_OK;
        o_busy        = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.op = OP_LOAD;
                end
            end
            S_DECODE: begin
                unique case (i_sts.cmd) inside
                    CMD_APPEND: begin
                        o_ctl.set_res = 1'b1;
                        if (i_sts.full) begin
                            o_ctl.st = ST_FULL;
                        end else begin
                            o_ctl.op   = OP_APPEND;
                            o_ctl.show = 1'b1;
                        end
                    end
                    CMD_REMOVE_AT, CMD_SET_ITER, CMD_GET_NTH: begin
                        if (i_sts.idx_ok) begin
                            o_ctl.op = OP_RD_IDX;
                        end else begin
                            o_ctl.set_res = 1'b1;
                            o_ctl.st      = ST_RANGE;
                        end
                    end
                    CMD_NEXT: begin
                        if (i_sts.iter_end) begin
                            o_ctl.set_res = 1'b1;
                            o_ctl.st      = ST_EMPTY;
                        end else begin
                            o_ctl.op = OP_RD_ITER;
                        end
                    end
                    CMD_RESET_ITER: begin
                        o_ctl.op      = OP_RST_ITER;
                        o_ctl.set_res = 1'b1;
                    end
                    CMD_CLOSEST, CMD_REMOVE_CLOSEST: begin
                        if (i_sts.empty) begin
                            o_ctl.set_res = 1'b1;
                            o_ctl.st      = ST_EMPTY;
                        end else begin
                            o_ctl.op = OP_SCAN_INIT;
                        end
                    end
                    default: o_ctl.op = OP_NONE;
                endcase
            end
            S_FETCH: begin
                o_ctl.set_res = 1'b1;
                o_ctl.show    = 1'b1;
                unique case (i_sts.cmd)
                    CMD_NEXT:     o_ctl.op = OP_FETCH_NEXT;
                    CMD_SET_ITER: o_ctl.op = OP_FETCH_SET;
                    default:      o_ctl.op = OP_FETCH;
                endcase
            end
            S_SCAN:  o_ctl.op = OP_SCAN;
            S_DRAIN: o_ctl.op = OP_NONE;
            S_DECIDE: begin
                if (i_sts.cmd == CMD_CLOSEST) begin
                    o_ctl.set_res = 1'b1;
                    o_ctl.show    = 1'b1;
                end else if (!i_sts.in_radius) begin
                    o_ctl.set_res = 1'b1;
                    o_ctl.st      = ST_RADIUS;
                    o_ctl.show    = 1'b1;
                end
            end
            S_SHINIT: o_ctl.op = OP_SHIFT_INIT;
            S_SHIFT: begin
                if (i_sts.shift_done) begin
                    o_ctl.op      = OP_REMOVE;
                    o_ctl.set_res = 1'b1;
                    o_ctl.show    = 1'b1;
                end else begin
                    o_ctl.op = OP_SHIFT;
                end
            end
            S_EMIT:  o_ctl.op = OP_EMIT;
            default: o_ctl.op = OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pts_dp.sv =====
// Datapath: point memory, count and iterator, distance pipeline, result registers.
`default_nettype none

module pts_dp
    import pts_pkg::*;
#(
    parameter int DEPTH        = 64,
    parameter int COORD_BITS   = 12,
    parameter int PAYLOAD_BITS = 24
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_dp_ctl                 i_ctl,
    output t_dp_sts                      o_sts,
    input  wire logic [CMD_W-1:0]        i_cmd,
    input  wire logic [COORD_BITS-1:0]   i_x_coord,
    input  wire logic [COORD_BITS-1:0]   i_y_coord,
    input  wire logic [PAYLOAD_BITS-1:0] i_payload,
    input  wire logic [IDXIN_W-1:0]      i_item_index,
    input  wire logic [RADIUS_W-1:0]     i_radius,
    output logic                         o_strobe,
    output logic [ST_W-1:0]              o_status,
    output logic [RIDX_W-1:0]            o_result_index,
    output logic [COORD_BITS-1:0]        o_out_x,
    output logic [COORD_BITS-1:0]        o_out_y,
    output logic [PAYLOAD_BITS-1:0]      o_out_payload,
    output logic [CNTOUT_W-1:0]          o_entry_count
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PT_W  = 2 * COORD_BITS + PAYLOAD_BITS;
    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int DW    = SQ_W + 1;
    localparam int RW    = (DW > R2_W) ? DW : R2_W;
    localparam int CMP_W = (CNT_W > IDXIN_W) ? CNT_W : IDXIN_W;
    localparam int X_LO  = COORD_BITS + PAYLOAD_BITS;
    localparam int Y_LO  = PAYLOAD_BITS;

    logic [PT_W-1:0]         mem [DEPTH];

    t_cmd                    r_cmd;
    logic [COORD_BITS-1:0]   r_x;
    logic [COORD_BITS-1:0]   r_y;
    logic [PAYLOAD_BITS-1:0] r_pl;
    logic [IDXIN_W-1:0]      r_idx;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        r_iter;
    logic [CNT_W-1:0]        r_ptr;
    logic [PT_W-1:0]         r_rd;
    logic [IDX_W-1:0]        r_rd_addr;
    logic                    r_v1;
    logic                    r_v2;
    logic                    r_v3;
    logic [IDX_W-1:0]        r_i2;
    logic [IDX_W-1:0]        r_i3;
    logic [PT_W-1:0]         r_p2;
    logic [PT_W-1:0]         r_p3;
    logic [COORD_BITS-1:0]   r_dx;
    logic [COORD_BITS-1:0]   r_dy;
    logic [SQ_W-1:0]         r_sx;
    logic [SQ_W-1:0]         r_sy;
    logic [DW-1:0]           r_bd;
    logic [IDX_W-1:0]        r_best_idx;
    logic [PT_W-1:0]         r_best_pt;
    logic [R2_W-1:0]         r_r2;
    logic                    r_sv;
    logic [IDX_W-1:0]        r_swa;
    t_status                 r_st;
    logic                    r_show;

    logic [IDX_W-1:0]        raddr;
    logic                    we;
    logic [IDX_W-1:0]        waddr;
    logic [PT_W-1:0]         wdata;
    logic [DW-1:0]           sq_sum;
    logic                    issue;
    logic [COORD_BITS-1:0]   rd_x;
    logic [COORD_BITS-1:0]   rd_y;

    assign rd_x   = r_rd[X_LO +: COORD_BITS];
    assign rd_y   = r_rd[Y_LO +: COORD_BITS];
    assign sq_sum = DW'(r_sx) + DW'(r_sy);
    assign issue  = (r_ptr < r_count);

    always_comb begin
        case (i_ctl.op)
            OP_RD_IDX:  raddr = IDX_W'(r_idx);
            OP_RD_ITER: raddr = r_iter[IDX_W-1:0];
            default:    raddr = r_ptr[IDX_W-1:0];
        endcase
        we    = (i_ctl.op == OP_APPEND) || r_sv;
        waddr = r_sv ? r_swa : r_count[IDX_W-1:0];
        wdata = r_sv ? r_rd : {r_x, r_y, r_pl};
    end

    always_comb begin
        o_sts.cmd        = r_cmd;
        o_sts.full       = (r_count == CNT_W'(DEPTH));
        o_sts.empty      = (r_count == '0);
        o_sts.idx_ok     = (CMP_W'(r_idx) < CMP_W'(r_count));
        o_sts.iter_end   = (r_iter >= r_count);
        o_sts.scan_last  = (r_ptr == r_count - CNT_W'(1));
        o_sts.pipe_busy  = r_v1 | r_v2 | r_v3;
        o_sts.shift_done = !issue && !r_sv;
        o_sts.in_radius  = (RW'(r_bd) <= RW'(r_r2));
    end

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd      <= mem[raddr];
        r_rd_addr <= raddr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_iter   <= '0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_sv     <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            case (i_ctl.op)
                OP_APPEND: begin
                    if (r_count != '0 && r_iter >= r_count) begin
                        r_iter <= r_count + CNT_W'(1);
                    end
                    r_count <= r_count + CNT_W'(1);
                end
                OP_RST_ITER:   r_iter <= '0;
                OP_FETCH_NEXT: r_iter <= CNT_W'(r_rd_addr) + CNT_W'(1);
                OP_FETCH_SET:  r_iter <= CNT_W'(r_rd_addr);
                OP_REMOVE: begin
                    r_count <= r_count - CNT_W'(1);
                    if (r_iter > CNT_W'(r_best_idx)) begin
                        r_iter <= r_iter - CNT_W'(1);
                    end
                end
                default: r_iter <= r_iter;
            endcase
            r_v1     <= (i_ctl.op == OP_SCAN);
            r_v2     <= r_v1;
            r_v3     <= r_v2;
            r_sv     <= (i_ctl.op == OP_SHIFT) && issue;
            o_strobe <= (i_ctl.op == OP_EMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctl.op) inside
            OP_LOAD: begin
                r_cmd <= t_cmd'(i_cmd);
                r_x   <= i_x_coord;
                r_y   <= i_y_coord;
                r_pl  <= i_payload;
                r_idx <= i_item_index;
            end
            OP_APPEND: begin
                r_best_pt  <= {r_x, r_y, r_pl};
                r_best_idx <= r_count[IDX_W-1:0];
            end
            OP_FETCH, OP_FETCH_NEXT, OP_FETCH_SET: begin
                r_best_pt  <= r_rd;
                r_best_idx <= r_rd_addr;
            end
            OP_SCAN_INIT: begin
                r_ptr <= '0;
                r_bd  <= '1;
            end
            OP_SCAN:       r_ptr <= r_ptr + CNT_W'(1);
            OP_SHIFT_INIT: r_ptr <= CNT_W'(r_best_idx) + CNT_W'(1);
            OP_SHIFT: begin
                if (issue) begin
                    r_ptr <= r_ptr + CNT_W'(1);
                end
                r_swa <= r_ptr[IDX_W-1:0] - IDX_W'(1);
            end
            OP_EMIT: begin
                o_status       <= r_st;
                o_result_index <= r_show ? RIDX_W'(r_best_idx) : '0;
                o_out_x        <= r_show ? r_best_pt[X_LO +: COORD_BITS] : '0;
                o_out_y        <= r_show ? r_best_pt[Y_LO +: COORD_BITS] : '0;
                o_out_payload  <= r_show ? r_best_pt[PAYLOAD_BITS-1:0] : '0;
                o_entry_count  <= CNTOUT_W'(r_count);
            end
            default: r_ptr <= r_ptr;
        endcase

        // distance pipeline: abs diff, squares, compare (lowest index wins ties)
        r_dx <= (rd_x > r_x) ? rd_x - r_x : r_x - rd_x;
        r_dy <= (rd_y > r_y) ? rd_y - r_y : r_y - rd_y;
        r_p2 <= r_rd;
        r_i2 <= r_rd_addr;
        r_sx <= SQ_W'(r_dx) * SQ_W'(r_dx);
        r_sy <= SQ_W'(r_dy) * SQ_W'(r_dy);
        r_p3 <= r_p2;
        r_i3 <= r_i2;
        if (r_v3 && sq_sum < r_bd) begin
            r_bd       <= sq_sum;
            r_best_idx <= r_i3;
            r_best_pt  <= r_p3;
        end

        r_r2 <= R2_W'(i_radius) * R2_W'(i_radius);
        if (i_ctl.set_res) begin
            r_st   <= i_ctl.st;
            r_show <= i_ctl.show;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/point_table_nearest_search.sv =====
// Top level of the point table with nearest-neighbor search.
// Usage: raise start with a command while busy is low; the single result
// appears for one cycle with o_strobe and must be taken then, since the
// block cannot be held off. closest makes one memory read per entry to feed
// a three-stage squared-distance pipeline. remove_at, and remove_closest
// when the nearest entry lies within the erase radius, then compact the
// table, the walk moving one entry per cycle through the single memory
// write port. The erase radius is written over the cfg channel and resets
// to 16; the user must write it only while busy is low, as the block
// itself does not enforce this.
`default_nettype none

module point_table_nearest_search
    import pts_pkg::*;
#(
    parameter int DEPTH        = 64,
    parameter int COORD_BITS   = 12,
    parameter int PAYLOAD_BITS = 24
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [CMD_W-1:0]        i_cmd,
    input  wire logic [COORD_BITS-1:0]   i_x_coord,
    input  wire logic [COORD_BITS-1:0]   i_y_coord,
    input  wire logic [PAYLOAD_BITS-1:0] i_payload,
    input  wire logic [IDXIN_W-1:0]      i_item_index,
    output logic                         o_strobe,
    output logic [ST_W-1:0]              o_status,
    output logic [RIDX_W-1:0]            o_result_index,
    output logic [COORD_BITS-1:0]        o_out_x,
    output logic [COORD_BITS-1:0]        o_out_y,
    output logic [PAYLOAD_BITS-1:0]      o_out_payload,
    output logic [CNTOUT_W-1:0]          o_entry_count,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [RADIUS_W-1:0]     i_cfg_data
);

    logic [RADIUS_W-1:0] r_erase_radius;
    t_dp_ctl             ctl;
    t_dp_sts             sts;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_erase_radius <= RADIUS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_erase_radius <= i_cfg_data;
        end
    end

    pts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    pts_dp #(
        .DEPTH        (DEPTH),
        .COORD_BITS   (COORD_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .o_sts          (sts),
        .i_cmd          (i_cmd),
        .i_x_coord      (i_x_coord),
        .i_y_coord      (i_y_coord),
        .i_payload      (i_payload),
        .i_item_index   (i_item_index),
        .i_radius       (r_erase_radius),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_result_index (o_result_index),
        .o_out_x        (o_out_x),
        .o_out_y        (o_out_y),
        .o_out_payload  (o_out_payload),
        .o_entry_count  (o_entry_count)
    );

endmodule

`default_nettype wire

// ===== tb/pts_table_checker.sv =====
// Checker for point_table_nearest_search: predicts each result and compares it.
`timescale 1ns / 100ps

module pts_table_checker
    import pts_pkg::*;
#(
    parameter int DEPTH        = 64,
    parameter int COORD_BITS   = 12,
    parameter int PAYLOAD_BITS = 24
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic                    i_busy,
    input  wire logic [CMD_W-1:0]        i_cmd,
    input  wire logic [COORD_BITS-1:0]   i_x_coord,
    input  wire logic [COORD_BITS-1:0]   i_y_coord,
    input  wire logic [PAYLOAD_BITS-1:0] i_payload,
    input  wire logic [IDXIN_W-1:0]      i_item_index,
    input  wire logic                    i_strobe,
    input  wire logic [ST_W-1:0]         i_status,
    input  wire logic [RIDX_W-1:0]       i_result_index,
    input  wire logic [COORD_BITS-1:0]   i_out_x,
    input  wire logic [COORD_BITS-1:0]   i_out_y,
    input  wire logic [PAYLOAD_BITS-1:0] i_out_payload,
    input  wire logic [CNTOUT_W-1:0]     i_entry_count,
    input  wire logic                    i_cfg_valid,
    input  wire logic                    i_cfg_ready,
    input  wire logic [RADIUS_W-1:0]     i_cfg_data,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_fill_level
);

    typedef struct packed {
        t_status                 st;
        logic [RIDX_W-1:0]       ridx;
        logic [COORD_BITS-1:0]   x;
        logic [COORD_BITS-1:0]   y;
        logic [PAYLOAD_BITS-1:0] pl;
        logic [CNTOUT_W-1:0]     cnt;
    } t_table_result;

    logic [COORD_BITS-1:0]   pt_x  [DEPTH];
    logic [COORD_BITS-1:0]   pt_y  [DEPTH];
    logic [PAYLOAD_BITS-1:0] pt_pl [DEPTH];
    int                      fill;
    int                      iter_pos;
    logic [RADIUS_W-1:0]     radius;
    int                      fails = 0;
    t_table_result           expected_q [$];

    function automatic longint unsigned sq_dist(int i, logic [COORD_BITS-1:0] qx,
                                                logic [COORD_BITS-1:0] qy);
        longint unsigned dx, dy;
        dx = 64'((pt_x[i] > qx) ? pt_x[i] - qx : qx - pt_x[i]);
        dy = 64'((pt_y[i] > qy) ? pt_y[i] - qy : qy - pt_y[i]);
        return dx * dx + dy * dy;
    endfunction

    // lowest index wins a tie
    function automatic int nearest_entry(logic [COORD_BITS-1:0] qx,
                                         logic [COORD_BITS-1:0] qy);
        int              best;
        longint unsigned bd, d;
        best = 0;
        bd = sq_dist(0, qx, qy);
        for (int i = 1; i < fill; i++) begin
            d = sq_dist(i, qx, qy);
            if (d < bd) begin
                bd = d;
                best = i;
            end
        end
        return best;
    endfunction

    function automatic t_table_result entry_view(t_status st, int i);
        t_table_result r;
        r = '0;
        r.st = st;
        r.ridx = i[RIDX_W-1:0];
        r.x = pt_x[i];
        r.y = pt_y[i];
        r.pl = pt_pl[i];
        return r;
    endfunction

    // compaction: later entries move down, iterator follows
    function automatic void drop_entry(int i);
        for (int k = i; k + 1 < fill; k++) begin
            pt_x[k] = pt_x[k+1];
            pt_y[k] = pt_y[k+1];
            pt_pl[k] = pt_pl[k+1];
        end
        fill--;
        if (iter_pos > i) iter_pos--;
    endfunction

    function automatic t_table_result apply_table_cmd(t_cmd op,
                                                      logic [COORD_BITS-1:0] qx,
                                                      logic [COORD_BITS-1:0] qy,
                                                      logic [PAYLOAD_BITS-1:0] qpl,
                                                      logic [IDXIN_W-1:0] qidx);
        t_table_result r;
        int            n;
        int            qi;
        r = '0;
        r.st = ST_OK;
        qi = int'(qidx);
        case (op)
            CMD_APPEND: begin
                if (fill >= DEPTH) begin
                    r.st = ST_FULL;
                end else begin
                    pt_x[fill] = qx;
                    pt_y[fill] = qy;
                    pt_pl[fill] = qpl;
                    // iterator at end stays at end, except when appending to an empty table
                    if (fill > 0 && iter_pos >= fill) iter_pos = fill + 1;
                    r = entry_view(ST_OK, fill);
                    fill++;
                end
            end
            CMD_REMOVE_AT: begin
                if (qi >= fill) begin
                    r.st = ST_RANGE;
                end else begin
                    r = entry_view(ST_OK, qi);
                    drop_entry(qi);
                end
            end
            CMD_NEXT: begin
                if (iter_pos >= fill) begin
                    r.st = ST_EMPTY;
                end else begin
                    r = entry_view(ST_OK, iter_pos);
                    iter_pos++;
                end
            end
            CMD_RESET_ITER: begin
                iter_pos = 0;
            end
            CMD_SET_ITER: begin
                if (qi >= fill) begin
                    r.st = ST_RANGE;
                end else begin
                    iter_pos = qi;
                    r = entry_view(ST_OK, qi);
                end
            end
            CMD_CLOSEST: begin
                if (fill == 0) r.st = ST_EMPTY;
                else r = entry_view(ST_OK, nearest_entry(qx, qy));
            end
            CMD_GET_NTH: begin
                if (qi >= fill) r.st = ST_RANGE;
                else r = entry_view(ST_OK, qi);
            end
            CMD_REMOVE_CLOSEST: begin
                if (fill == 0) begin
                    r.st = ST_EMPTY;
                end else begin
                    n = nearest_entry(qx, qy);
                    if (sq_dist(n, qx, qy) > longint'(radius) * longint'(radius)) begin
                        r = entry_view(ST_RADIUS, n);
                    end else begin
                        r = entry_view(ST_OK, n);
                        drop_entry(n);
                    end
                end
            end
            default: ;
        endcase
        r.cnt = fill[CNTOUT_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            fails++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_table_result exp_r;
        if (!i_rst_n) begin
            fill = 0;
            iter_pos = 0;
            radius = RADIUS_RST;
            expected_q.delete();
        end else begin
            if (i_strobe) begin
                if (expected_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result: expected none, actual status %0d",
                             $time, i_status);
                end else begin
                    exp_r = expected_q.pop_front();
                    check_field("status", 32'(exp_r.st), 32'(i_status));
                    check_field("result_index", 32'(exp_r.ridx), 32'(i_result_index));
                    check_field("out_x", 32'(exp_r.x), 32'(i_out_x));
                    check_field("out_y", 32'(exp_r.y), 32'(i_out_y));
                    check_field("out_payload", 32'(exp_r.pl), 32'(i_out_payload));
                    check_field("entry_count", 32'(exp_r.cnt), 32'(i_entry_count));
                end
            end
            if (i_cfg_valid && i_cfg_ready) radius = i_cfg_data;
            if (i_start && !i_busy) begin
                expected_q.push_back(apply_table_cmd(t_cmd'(i_cmd), i_x_coord, i_y_coord,
                                                     i_payload, i_item_index));
            end
        end
        o_fail_count <= fails;
        o_pending <= expected_q.size();
        o_fill_level <= fill;
    end

endmodule

// ===== tb/tb_point_table_nearest_search.sv =====
// Testbench top for point_table_nearest_search: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_point_table_nearest_search
    import pts_pkg::*;
();

    localparam int DEPTH        = 64;
    localparam int COORD_BITS   = 12;
    localparam int PAYLOAD_BITS = 24;
    localparam int CMAX         = (1 << COORD_BITS) - 1;
    localparam int IDLE_LIMIT   = 2000;
    localparam int PHASE_ITEMS  = 225;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [CMD_W-1:0]        i_cmd;
    logic [COORD_BITS-1:0]   i_x_coord;
    logic [COORD_BITS-1:0]   i_y_coord;
    logic [PAYLOAD_BITS-1:0] i_payload;
    logic [IDXIN_W-1:0]      i_item_index;
    logic                    o_strobe;
    logic [ST_W-1:0]         o_status;
    logic [RIDX_W-1:0]       o_result_index;
    logic [COORD_BITS-1:0]   o_out_x;
    logic [COORD_BITS-1:0]   o_out_y;
    logic [PAYLOAD_BITS-1:0] o_out_payload;
    logic [CNTOUT_W-1:0]     o_entry_count;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [RADIUS_W-1:0]     i_cfg_data;

    int fail_count;
    int pending;
    int fill_level;
    int idle_pct = 0;
    int fill_goal = DEPTH;
    int idle_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    point_table_nearest_search #(
        .DEPTH(DEPTH), .COORD_BITS(COORD_BITS), .PAYLOAD_BITS(PAYLOAD_BITS)
    ) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cmd(i_cmd), .i_x_coord(i_x_coord), .i_y_coord(i_y_coord),
        .i_payload(i_payload), .i_item_index(i_item_index),
        .o_strobe(o_strobe), .o_status(o_status), .o_result_index(o_result_index),
        .o_out_x(o_out_x), .o_out_y(o_out_y), .o_out_payload(o_out_payload),
        .o_entry_count(o_entry_count),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    pts_table_checker #(
        .DEPTH(DEPTH), .COORD_BITS(COORD_BITS), .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_table_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_cmd(i_cmd), .i_x_coord(i_x_coord), .i_y_coord(i_y_coord),
        .i_payload(i_payload), .i_item_index(i_item_index),
        .i_strobe(o_strobe), .i_status(o_status), .i_result_index(o_result_index),
        .i_out_x(o_out_x), .i_out_y(o_out_y), .i_out_payload(o_out_payload),
        .i_entry_count(o_entry_count),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_fill_level(fill_level)
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input t_cmd op, input logic [COORD_BITS-1:0] qx,
                             input logic [COORD_BITS-1:0] qy,
                             input logic [PAYLOAD_BITS-1:0] qpl,
                             input logic [IDXIN_W-1:0] qidx);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= op;
        i_x_coord <= qx;
        i_y_coord <= qy;
        i_payload <= qpl;
        i_item_index <= qidx;
        do @(posedge i_clk); while (busy);
    endtask

    // hold off until the block is idle and every result is in
    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (busy || pending != 0);
    endtask

    task automatic write_radius(input logic [RADIUS_W-1:0] value);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // most points cluster in three spots so nearest hits land within the radius
    task automatic pick_point(output logic [COORD_BITS-1:0] qx,
                              output logic [COORD_BITS-1:0] qy);
        case ($urandom_range(3))
            0: begin
                qx = COORD_BITS'($urandom_range(CMAX));
                qy = COORD_BITS'($urandom_range(CMAX));
            end
            1: begin
                qx = COORD_BITS'($urandom_range(7));
                qy = COORD_BITS'($urandom_range(7));
            end
            2: begin
                qx = COORD_BITS'(CMAX - $urandom_range(7));
                qy = COORD_BITS'(CMAX - $urandom_range(7));
            end
            default: begin
                qx = COORD_BITS'((CMAX + 1) / 2 + $urandom_range(7));
                qy = COORD_BITS'((CMAX + 1) / 2 + $urandom_range(7));
            end
        endcase
    endtask

    initial begin
        start <= 1'b0;
        i_cmd <= CMD_RESET_ITER;
        i_x_coord <= '0;
        i_y_coord <= '0;
        i_payload <= '0;
        i_item_index <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= '0;
        i_rst_n <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table
        send_item(CMD_NEXT, 0, 0, 0, 0);
        send_item(CMD_CLOSEST, 12'd5, 12'd5, 0, 0);
        send_item(CMD_REMOVE_CLOSEST, 12'd5, 12'd5, 0, 0);
        send_item(CMD_REMOVE_AT, 0, 0, 0, 0);
        send_item(CMD_SET_ITER, 0, 0, 0, 0);
        // fill, with a duplicate point for the tie
        send_item(CMD_APPEND, 0, 0, 0, 0);
        send_item(CMD_APPEND, 12'hFFF, 12'hFFF, 24'hFFFFFF, 6'h3F);
        send_item(CMD_APPEND, 12'd100, 12'd100, 24'h123456, 0);
        send_item(CMD_APPEND, 12'd100, 12'd100, 24'h654321, 0);
        send_item(CMD_CLOSEST, 12'd101, 12'd101, 0, 0);
        send_item(CMD_GET_NTH, 0, 0, 0, 6'd3);
        send_item(CMD_SET_ITER, 0, 0, 0, 6'd3);
        send_item(CMD_NEXT, 0, 0, 0, 0);
        send_item(CMD_NEXT, 0, 0, 0, 0);
        // append with the iterator at end
        send_item(CMD_APPEND, 12'd4000, 12'd10, 24'hABCDEF, 0);
        send_item(CMD_NEXT, 0, 0, 0, 0);
        send_item(CMD_SET_ITER, 0, 0, 0, 6'd2);
        send_item(CMD_REMOVE_AT, 0, 0, 0, 6'd0);
        send_item(CMD_NEXT, 0, 0, 0, 0);
        send_item(CMD_REMOVE_CLOSEST, 12'd4090, 12'd4090, 0, 0);
        send_item(CMD_REMOVE_CLOSEST, 12'd2048, 12'd2048, 0, 0);
        // remove under the iterator
        send_item(CMD_SET_ITER, 0, 0, 0, 6'd1);
        send_item(CMD_REMOVE_AT, 0, 0, 0, 6'd1);
        send_item(CMD_NEXT, 0, 0, 0, 0);
        send_item(CMD_RESET_ITER, 0, 0, 0, 0);
        send_item(CMD_GET_NTH, 0, 0, 0, 6'd63);
        settle();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_radius('0);
                1: write_radius('1);
                2: write_radius(RADIUS_W'($urandom_range(1, 4094)));
                default: write_radius(RADIUS_RST);
            endcase
            idle_pct = (ph == 1) ? 59 : (ph == 3) ? 38 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                t_cmd                    op;
                logic [COORD_BITS-1:0]   qx, qy;
                logic [IDXIN_W-1:0]      qidx;
                int                      r;
                bit                      grow;
                if (n % 40 == 0) begin
                    case ($urandom_range(2))
                        0: fill_goal = 0;
                        1: fill_goal = DEPTH;
                        default: fill_goal = $urandom_range(DEPTH);
                    endcase
                end
                if (n == PHASE_ITEMS / 2) settle();
                grow = (fill_level < fill_goal) || (fill_goal == DEPTH);
                r = $urandom_range(99);
                if (r < (grow ? 50 : 8)) op = CMD_APPEND;
                else if (!grow && r < 45) op = r[0] ? CMD_REMOVE_AT : CMD_REMOVE_CLOSEST;
                else op = t_cmd'($urandom_range(1, 7));
                pick_point(qx, qy);
                if (fill_level > 0 && $urandom_range(4) != 0)
                    qidx = IDXIN_W'($urandom_range(fill_level - 1));
                else qidx = IDXIN_W'($urandom_range(63));
                send_item(op, qx, qy, PAYLOAD_BITS'($urandom_range(24'hFFFFFF)), qidx);
            end
        end

        settle();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/pts_pkg.sv
hw/rtl/pts_ctrl.sv
hw/rtl/pts_dp.sv
hw/rtl/point_table_nearest_search.sv
tb/pts_table_checker.sv
tb/tb_point_table_nearest_search.sv
